FILE: rtl/adp_pkg.sv
// Shared types and codes for the ARM data-processing ALU.
// No dependencies; used by adp_shifter and arm_data_processing_alu.
package adp_pkg;

    // ALU opcodes in ARM encoding order
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_alu_op;

    // Barrel shifter operations
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_type;

    // Second operand forms; the unused code acts as register-shifted-by-register
    typedef enum logic [1:0] {
        FORM_ROT_IMM   = 2'd0,
        FORM_SHIFT_IMM = 2'd1,
        FORM_SHIFT_REG = 2'd2
    } t_operand_form;

    localparam int unsigned DATA_W = 32;

    // Shift amounts above this saturate: everything shifted out, carry clear; ASR sign-fills
    localparam logic [7:0] FULL_SHIFT = 8'd32;
    localparam logic [5:0] OVER_SHIFT = 6'd33;

endpackage

FILE: rtl/adp_shifter.sv
// Barrel shifter for the second operand: rotated immediate, register shifted
// by immediate (with LSR/ASR #32 and RRX encodings) or by register. Uses adp_pkg.
module adp_shifter (
    input  adp_pkg::t_operand_form      i_form,
    input  adp_pkg::t_shift_type        i_shift_type,
    input  logic [7:0]                  i_shift_amount,
    input  logic [adp_pkg::DATA_W-1:0]  i_value,
    input  logic [7:0]                  i_immediate_byte,
    input  logic [3:0]                  i_rotate_half,
    input  logic                        i_carry_in,
    output logic [adp_pkg::DATA_W-1:0]  o_value,
    output logic                        o_carry
);

    logic [31:0]        imm_word;
    logic [63:0]        imm_dbl;
    logic [4:0]         imm_rot;
    logic [31:0]        imm_val;
    logic [7:0]         amt_eff;
    logic               keep;
    logic               rrx;
    logic [5:0]         amt_sat;
    logic [32:0]        lsl_ext;
    logic [32:0]        lsr_ext;
    logic signed [32:0] asr_src;
    logic [32:0]        asr_ext;
    logic [63:0]        ror_dbl;
    logic [31:0]        ror_val;
    logic [31:0]        reg_val;
    logic               reg_carry;

    // Rotate the 8-bit immediate right by twice the rotate field
    assign imm_word = {24'd0, i_immediate_byte};
    assign imm_rot  = {i_rotate_half, 1'b0};
    assign imm_dbl  = {imm_word, imm_word} >> imm_rot;
    assign imm_val  = imm_dbl[31:0];

    // Map encodings to an effective amount; zero immediate means LSL #0, #32 or RRX
    always_comb begin
        amt_eff = i_shift_amount;
        keep    = 1'b0;
        rrx     = 1'b0;
        if (i_form == adp_pkg::FORM_SHIFT_IMM) begin
            amt_eff = {3'd0, i_shift_amount[4:0]};
            if (i_shift_amount[4:0] == 5'd0) begin
                unique case (i_shift_type)
                    adp_pkg::SH_LSL: keep    = 1'b1;
                    adp_pkg::SH_LSR: amt_eff = adp_pkg::FULL_SHIFT;
                    adp_pkg::SH_ASR: amt_eff = adp_pkg::FULL_SHIFT;
                    adp_pkg::SH_ROR: rrx     = 1'b1;
                endcase
            end
        end else begin
            keep = (i_shift_amount == 8'd0);
        end
    end

    // Saturate: anything past 32 shifts every bit out, carry included; ASR fills with the sign
    assign amt_sat = (amt_eff > adp_pkg::FULL_SHIFT) ? adp_pkg::OVER_SHIFT : amt_eff[5:0];

    // Extend by one bit so the last bit shifted out lands in the carry slot
    assign lsl_ext = {1'b0, i_value} << amt_sat;
    assign lsr_ext = {i_value, 1'b0} >> amt_sat;
    assign asr_src = {i_value, 1'b0};
    assign asr_ext = asr_src >>> amt_sat;
    assign ror_dbl = {i_value, i_value} >> amt_eff[4:0];
    assign ror_val = ror_dbl[31:0];

    // Select the register shift result
    always_comb begin
        unique case (i_shift_type)
            adp_pkg::SH_LSL: begin
                reg_val   = lsl_ext[31:0];
                reg_carry = lsl_ext[32];
            end
            adp_pkg::SH_LSR: begin
                reg_val   = lsr_ext[32:1];
                reg_carry = lsr_ext[0];
            end
            adp_pkg::SH_ASR: begin
                reg_val   = asr_ext[32:1];
                reg_carry = asr_ext[0];
            end
            adp_pkg::SH_ROR: begin
                reg_val   = ror_val;
                reg_carry = ror_val[31];
            end
        endcase
    end

    // Pick the operand by form, with the unchanged and RRX special cases
    always_comb begin
        if (i_form == adp_pkg::FORM_ROT_IMM) begin
            o_value = imm_val;
            o_carry = (i_rotate_half == 4'd0) ? i_carry_in : imm_val[31];
        end else if (keep) begin
            o_value = i_value;
            o_carry = i_carry_in;
        end else if (rrx) begin
            o_value = {i_carry_in, i_value[31:1]};
            o_carry = i_value[0];
        end else begin
            o_value = reg_val;
            o_carry = reg_carry;
        end
    end

endmodule

FILE: rtl/arm_data_processing_alu.sv
// ARM data-processing execute stage: shifter plus sixteen-op ALU.
// Depends on adp_pkg and adp_shifter.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------
//  input   | i_in_valid / o_in_ready     | command, operands, shift, flags in
//  output  | o_out_valid / i_out_ready   | result, routing bits, N Z C V
//
// One item per cycle while the output is not stalled: an input register, one pass of
// shifter and 32-bit adder, then a result register that drives the output.
// Reset clears both valid bits; payload registers are not reset.
// A stalled result holds in the output register while the input register
// still takes one more item; input ready drops only when both are full.
module arm_data_processing_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_command,
    input  logic        i_set_flags,
    input  logic [1:0]  i_operand_form,
    input  logic [1:0]  i_shift_type,
    input  logic [7:0]  i_shift_amount,
    input  logic [31:0] i_first_operand,
    input  logic [31:0] i_second_register,
    input  logic [7:0]  i_immediate_byte,
    input  logic [3:0]  i_rotate_half,
    input  logic        i_carry_in,
    input  logic        i_overflow_in,
    input  logic        i_dest_is_pc,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result,
    output logic        o_write_back,
    output logic        o_branch_taken,
    output logic        o_restore_status,
    output logic        o_flags_update,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_c,
    output logic        o_flag_v
);

    // Input register
    logic                    r_in_valid;
    adp_pkg::t_alu_op        r_command;
    logic                    r_set_flags;
    adp_pkg::t_operand_form  r_form;
    adp_pkg::t_shift_type    r_shift_type;
    logic [7:0]              r_shift_amount;
    logic [31:0]             r_first_operand;
    logic [31:0]             r_second_register;
    logic [7:0]              r_immediate_byte;
    logic [3:0]              r_rotate_half;
    logic                    r_carry_in;
    logic                    r_overflow_in;
    logic                    r_dest_is_pc;

    // Result register
    logic                    r_out_valid;
    logic [31:0]             r_result;
    logic                    r_write_back;
    logic                    r_branch_taken;
    logic                    r_restore_status;
    logic                    r_flags_update;
    logic                    r_flag_n;
    logic                    r_flag_z;
    logic                    r_flag_c;
    logic                    r_flag_v;

    logic                    out_load;
    logic                    in_load;

    logic [31:0]             op_b;
    logic                    shift_carry;
    logic [31:0]             add_x;
    logic [31:0]             add_y;
    logic                    add_cin;
    logic [32:0]             add_sum;
    logic                    add_v;
    logic                    is_arith;
    logic                    is_test;

    logic [31:0]             n_result;
    logic                    n_write_back;
    logic                    n_branch_taken;
    logic                    n_restore_status;
    logic                    n_flags_update;
    logic                    n_flag_c;
    logic                    n_flag_v;

    // Advance the result stage when it is empty or being drained
    assign out_load   = !r_out_valid || i_out_ready;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_ready = in_load;

    // Capture an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
        if (in_load && i_in_valid) begin
            r_command         <= adp_pkg::t_alu_op'(i_command);
            r_set_flags       <= i_set_flags;
            r_form            <= adp_pkg::t_operand_form'(i_operand_form);
            r_shift_type      <= adp_pkg::t_shift_type'(i_shift_type);
            r_shift_amount    <= i_shift_amount;
            r_first_operand   <= i_first_operand;
            r_second_register <= i_second_register;
            r_immediate_byte  <= i_immediate_byte;
            r_rotate_half     <= i_rotate_half;
            r_carry_in        <= i_carry_in;
            r_overflow_in     <= i_overflow_in;
            r_dest_is_pc      <= i_dest_is_pc;
        end
    end

    adp_shifter u_shifter (
        .i_form           (r_form),
        .i_shift_type     (r_shift_type),
        .i_shift_amount   (r_shift_amount),
        .i_value          (r_second_register),
        .i_immediate_byte (r_immediate_byte),
        .i_rotate_half    (r_rotate_half),
        .i_carry_in       (r_carry_in),
        .o_value          (op_b),
        .o_carry          (shift_carry)
    );

    // Set up adder operands; subtraction adds the complement
    always_comb begin
        add_x    = r_first_operand;
        add_y    = op_b;
        add_cin  = 1'b0;
        is_arith = 1'b1;
        unique case (r_command)
            adp_pkg::OP_SUB, adp_pkg::OP_CMP: begin
                add_y   = ~op_b;
                add_cin = 1'b1;
            end
            adp_pkg::OP_RSB: begin
                add_x   = op_b;
                add_y   = ~r_first_operand;
                add_cin = 1'b1;
            end
            adp_pkg::OP_ADD, adp_pkg::OP_CMN: begin
                add_cin = 1'b0;
            end
            adp_pkg::OP_ADC: begin
                add_cin = r_carry_in;
            end
            adp_pkg::OP_SBC: begin
                add_y   = ~op_b;
                add_cin = r_carry_in;
            end
            adp_pkg::OP_RSC: begin
                add_x   = op_b;
                add_y   = ~r_first_operand;
                add_cin = r_carry_in;
            end
            adp_pkg::OP_AND, adp_pkg::OP_EOR, adp_pkg::OP_TST, adp_pkg::OP_TEQ,
            adp_pkg::OP_ORR, adp_pkg::OP_MOV, adp_pkg::OP_BIC,
            adp_pkg::OP_MVN: begin
                is_arith = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_v   = (add_x[31] ^ add_sum[31]) & (add_y[31] ^ add_sum[31]);

    // Select the ALU result
    always_comb begin
        unique case (r_command)
            adp_pkg::OP_AND, adp_pkg::OP_TST: n_result = r_first_operand & op_b;
            adp_pkg::OP_EOR, adp_pkg::OP_TEQ: n_result = r_first_operand ^ op_b;
            adp_pkg::OP_ORR:                  n_result = r_first_operand | op_b;
            adp_pkg::OP_MOV:                  n_result = op_b;
            adp_pkg::OP_BIC:                  n_result = r_first_operand & ~op_b;
            adp_pkg::OP_MVN:                  n_result = ~op_b;
            adp_pkg::OP_SUB, adp_pkg::OP_RSB, adp_pkg::OP_ADD, adp_pkg::OP_ADC,
            adp_pkg::OP_SBC, adp_pkg::OP_RSC, adp_pkg::OP_CMP,
            adp_pkg::OP_CMN:                  n_result = add_sum[31:0];
        endcase
    end

    // Logical ops take carry from the shifter and keep V
    assign n_flag_c = is_arith ? add_sum[32] : shift_carry;
    assign n_flag_v = is_arith ? add_v : r_overflow_in;

    // Route the result; compare and test ops always write flags only
    assign is_test = (r_command[3:2] == 2'b10);
    always_comb begin
        if (is_test) begin
            n_write_back     = 1'b0;
            n_branch_taken   = 1'b0;
            n_restore_status = 1'b0;
            n_flags_update   = 1'b1;
        end else begin
            n_write_back     = !r_dest_is_pc;
            n_branch_taken   = r_dest_is_pc;
            n_restore_status = r_set_flags && r_dest_is_pc;
            n_flags_update   = r_set_flags && !r_dest_is_pc;
        end
    end

    // Load the result register; hold while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
        if (out_load && r_in_valid) begin
            r_result         <= n_result;
            r_write_back     <= n_write_back;
            r_branch_taken   <= n_branch_taken;
            r_restore_status <= n_restore_status;
            r_flags_update   <= n_flags_update;
            r_flag_n         <= n_result[31];
            r_flag_z         <= (n_result == 32'd0);
            r_flag_c         <= n_flag_c;
            r_flag_v         <= n_flag_v;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result         = r_result;
    assign o_write_back     = r_write_back;
    assign o_branch_taken   = r_branch_taken;
    assign o_restore_status = r_restore_status;
    assign o_flags_update   = r_flags_update;
    assign o_flag_n         = r_flag_n;
    assign o_flag_z         = r_flag_z;
    assign o_flag_c         = r_flag_c;
    assign o_flag_v         = r_flag_v;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for arm_data_processing_alu: barrel shifter and sixteen ALU ops.
// Depends on adp_pkg and the RTL; predicts every result word and checks it in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Spare operand-form code; the block treats it as register shifted by register
    localparam logic [1:0] FORM_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        adp_pkg::t_alu_op     command;
        logic                 set_flags;
        logic [1:0]           operand_form;
        adp_pkg::t_shift_type shift_type;
        logic [7:0]           shift_amount;
        logic [31:0]          first_operand;
        logic [31:0]          second_register;
        logic [7:0]           immediate_byte;
        logic [3:0]           rotate_half;
        logic                 carry_in;
        logic                 overflow_in;
        logic                 dest_is_pc;
    } t_alu_instr;

    typedef struct {
        logic [31:0] result;
        logic        write_back;
        logic        branch_taken;
        logic        restore_status;
        logic        flags_update;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
    } t_alu_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_command;
    logic        i_set_flags;
    logic [1:0]  i_operand_form;
    logic [1:0]  i_shift_type;
    logic [7:0]  i_shift_amount;
    logic [31:0] i_first_operand;
    logic [31:0] i_second_register;
    logic [7:0]  i_immediate_byte;
    logic [3:0]  i_rotate_half;
    logic        i_carry_in;
    logic        i_overflow_in;
    logic        i_dest_is_pc;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_result;
    logic        o_write_back;
    logic        o_branch_taken;
    logic        o_restore_status;
    logic        o_flags_update;
    logic        o_flag_n;
    logic        o_flag_z;
    logic        o_flag_c;
    logic        o_flag_v;

    t_alu_instr   pending_instrs[$];
    t_alu_outcome predicted_outcomes[$];
    t_alu_instr   current_instr;
    t_alu_outcome oldest_outcome;
    bit           instr_taken;
    int           sender_idle_pct;
    int           sink_stall_pct;
    int           error_count;
    int           cycle_count;

    arm_data_processing_alu dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_set_flags       (i_set_flags),
        .i_operand_form    (i_operand_form),
        .i_shift_type      (i_shift_type),
        .i_shift_amount    (i_shift_amount),
        .i_first_operand   (i_first_operand),
        .i_second_register (i_second_register),
        .i_immediate_byte  (i_immediate_byte),
        .i_rotate_half     (i_rotate_half),
        .i_carry_in        (i_carry_in),
        .i_overflow_in     (i_overflow_in),
        .i_dest_is_pc      (i_dest_is_pc),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result          (o_result),
        .o_write_back      (o_write_back),
        .o_branch_taken    (o_branch_taken),
        .o_restore_status  (o_restore_status),
        .o_flags_update    (o_flags_update),
        .o_flag_n          (o_flag_n),
        .o_flag_z          (o_flag_z),
        .o_flag_c          (o_flag_c),
        .o_flag_v          (o_flag_v)
    );

    // Run a 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotate_right(logic [31:0] x, logic [4:0] n);
        logic [63:0] both;
        both = {x, x} >> n;
        return both[31:0];
    endfunction

    // Form the second operand and the shifter carry
    function automatic void shift_second(input t_alu_instr w, output logic [31:0] b,
                                         output logic c);
        logic [31:0] x;
        logic [4:0]  s;
        logic [7:0]  n;
        x = w.second_register;
        s = w.shift_amount[4:0];
        n = w.shift_amount;
        b = x;
        c = w.carry_in;
        if (w.operand_form == adp_pkg::FORM_ROT_IMM) begin
            b = rotate_right({24'd0, w.immediate_byte}, {w.rotate_half, 1'b0});
            if (w.rotate_half != 4'd0) c = b[31];
        end else if (w.operand_form == adp_pkg::FORM_SHIFT_IMM) begin
            // a zero immediate amount means LSL #0, LSR #32, ASR #32 or RRX
            case (w.shift_type)
                adp_pkg::SH_LSL: if (s != 5'd0) begin
                    b = x << s;
                    c = x[32 - s];
                end
                adp_pkg::SH_LSR: if (s == 5'd0) begin
                    b = '0;
                    c = x[31];
                end else begin
                    b = x >> s;
                    c = x[s - 1];
                end
                adp_pkg::SH_ASR: if (s == 5'd0) begin
                    b = {32{x[31]}};
                    c = x[31];
                end else begin
                    b = $signed(x) >>> s;
                    c = x[s - 1];
                end
                default: if (s == 5'd0) begin
                    b = {w.carry_in, x[31:1]};
                    c = x[0];
                end else begin
                    b = rotate_right(x, s);
                    c = x[s - 1];
                end
            endcase
        end else if (n != 8'd0) begin
            // register amount: all eight bits count, zero leaves value and carry
            case (w.shift_type)
                adp_pkg::SH_LSL: if (n < 8'd32) begin
                    b = x << n;
                    c = x[32 - n];
                end else begin
                    b = '0;
                    c = (n == 8'd32) ? x[0] : 1'b0;
                end
                adp_pkg::SH_LSR: if (n < 8'd32) begin
                    b = x >> n;
                    c = x[n - 1];
                end else begin
                    b = '0;
                    c = (n == 8'd32) ? x[31] : 1'b0;
                end
                adp_pkg::SH_ASR: if (n < 8'd32) begin
                    b = $signed(x) >>> n;
                    c = x[n - 1];
                end else begin
                    b = {32{x[31]}};
                    c = x[31];
                end
                default: if (n[4:0] == 5'd0) begin
                    c = x[31];
                end else begin
                    b = rotate_right(x, n[4:0]);
                    c = x[n[4:0] - 1];
                end
            endcase
        end
    endfunction

    function automatic void add_with_flags(input logic [31:0] x, input logic [31:0] y,
                                           input logic cin, output logic [31:0] sum,
                                           output logic cout, output logic vout);
        logic [32:0] wide;
        wide = {1'b0, x} + {1'b0, y} + {32'd0, cin};
        sum  = wide[31:0];
        cout = wide[32];
        vout = (x[31] ^ sum[31]) & (y[31] ^ sum[31]);
    endfunction

    // Predict the result word of one instruction
    function automatic t_alu_outcome execute_instr(t_alu_instr w);
        t_alu_outcome r;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  res;
        logic         c;
        logic         v;
        logic         is_test;
        shift_second(w, b, c);
        a = w.first_operand;
        v = w.overflow_in;
        case (w.command)
            adp_pkg::OP_AND, adp_pkg::OP_TST: res = a & b;
            adp_pkg::OP_EOR, adp_pkg::OP_TEQ: res = a ^ b;
            adp_pkg::OP_SUB, adp_pkg::OP_CMP: add_with_flags(a, ~b, 1'b1, res, c, v);
            adp_pkg::OP_RSB:         add_with_flags(b, ~a, 1'b1, res, c, v);
            adp_pkg::OP_ADD, adp_pkg::OP_CMN: add_with_flags(a, b, 1'b0, res, c, v);
            adp_pkg::OP_ADC:         add_with_flags(a, b, w.carry_in, res, c, v);
            adp_pkg::OP_SBC:         add_with_flags(a, ~b, w.carry_in, res, c, v);
            adp_pkg::OP_RSC:         add_with_flags(b, ~a, w.carry_in, res, c, v);
            adp_pkg::OP_ORR:         res = a | b;
            adp_pkg::OP_MOV:         res = b;
            adp_pkg::OP_BIC:         res = a & ~b;
            default:                 res = ~b;
        endcase
        // compare and test ops always write flags and never route the result
        is_test = w.command inside {adp_pkg::OP_TST, adp_pkg::OP_TEQ,
                                    adp_pkg::OP_CMP, adp_pkg::OP_CMN};
        r.result         = res;
        r.write_back     = !is_test && !w.dest_is_pc;
        r.branch_taken   = !is_test && w.dest_is_pc;
        r.restore_status = !is_test && w.set_flags && w.dest_is_pc;
        r.flags_update   = is_test || (w.set_flags && !w.dest_is_pc);
        r.flag_n         = res[31];
        r.flag_z         = (res == 32'd0);
        r.flag_c         = c;
        r.flag_v         = v;
        return r;
    endfunction

    function automatic t_alu_instr make_instr(adp_pkg::t_alu_op cmd, logic s,
                                              logic [1:0] form,
                                              adp_pkg::t_shift_type st, logic [7:0] amount,
                                              logic [31:0] a, logic [31:0] rm,
                                              logic [7:0] imm, logic [3:0] rot,
                                              logic cin, logic vin, logic pc);
        t_alu_instr w;
        w.command         = cmd;
        w.set_flags       = s;
        w.operand_form    = form;
        w.shift_type      = st;
        w.shift_amount    = amount;
        w.first_operand   = a;
        w.second_register = rm;
        w.immediate_byte  = imm;
        w.rotate_half     = rot;
        w.carry_in        = cin;
        w.overflow_in     = vin;
        w.dest_is_pc      = pc;
        return w;
    endfunction

    // Favor boundary values for register operands
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic compare_flag(string name, logic got, logic want);
        if (got !== want)
            report_error($sformatf("%s got %b want %b", name, got, want));
    endtask

    // Queue random instructions with boundary-heavy shift amounts
    task automatic queue_random_instrs(int count);
        t_alu_instr w;
        int         pick;
        repeat (count) begin
            w.command         = adp_pkg::t_alu_op'($urandom_range(15));
            w.set_flags       = 1'($urandom_range(1));
            pick              = $urandom_range(9);
            w.operand_form    = (pick < 3) ? adp_pkg::FORM_ROT_IMM :
                                (pick < 6) ? adp_pkg::FORM_SHIFT_IMM :
                                (pick < 9) ? adp_pkg::FORM_SHIFT_REG : FORM_SPARE;
            w.shift_type      = adp_pkg::t_shift_type'($urandom_range(3));
            case ($urandom_range(3))
                0:       w.shift_amount = 8'($urandom_range(33));
                1:       w.shift_amount = 8'(32 * $urandom_range(7));
                default: w.shift_amount = 8'($urandom_range(255));
            endcase
            w.first_operand   = pick_operand();
            w.second_register = pick_operand();
            w.immediate_byte  = 8'($urandom_range(255));
            w.rotate_half     = 4'($urandom_range(15));
            w.carry_in        = 1'($urandom_range(1));
            w.overflow_in     = 1'($urandom_range(1));
            w.dest_is_pc      = ($urandom_range(3) == 0);
            pending_instrs.push_back(w);
        end
    endtask

    // Hold until every queued word has gone in and every result word is back
    task automatic wait_for_drain();
        while (pending_instrs.size() != 0 || i_in_valid || predicted_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        queue_random_instrs(count);
        wait_for_drain();
    endtask

    // Drive the input channel: hold a word until taken, then maybe present the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || instr_taken) begin
            if (pending_instrs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                current_instr = pending_instrs.pop_front();
                i_command         <= current_instr.command;
                i_set_flags       <= current_instr.set_flags;
                i_operand_form    <= current_instr.operand_form;
                i_shift_type      <= current_instr.shift_type;
                i_shift_amount    <= current_instr.shift_amount;
                i_first_operand   <= current_instr.first_operand;
                i_second_register <= current_instr.second_register;
                i_immediate_byte  <= current_instr.immediate_byte;
                i_rotate_half     <= current_instr.rotate_half;
                i_carry_in        <= current_instr.carry_in;
                i_overflow_in     <= current_instr.overflow_in;
                i_dest_is_pc      <= current_instr.dest_is_pc;
                i_in_valid        <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Record accepted words, check result words, and enforce the cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            report_error($sformatf("timeout after %0d cycles", cycle_count));
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_outcomes.size() == 0) begin
                report_error($sformatf("result word %h with nothing pending", o_result));
            end else begin
                oldest_outcome = predicted_outcomes.pop_front();
                compare_field("result", o_result, oldest_outcome.result);
                compare_flag("write_back", o_write_back, oldest_outcome.write_back);
                compare_flag("branch_taken", o_branch_taken, oldest_outcome.branch_taken);
                compare_flag("restore_status", o_restore_status,
                             oldest_outcome.restore_status);
                compare_flag("flags_update", o_flags_update, oldest_outcome.flags_update);
                compare_flag("flag_n", o_flag_n, oldest_outcome.flag_n);
                compare_flag("flag_z", o_flag_z, oldest_outcome.flag_z);
                compare_flag("flag_c", o_flag_c, oldest_outcome.flag_c);
                compare_flag("flag_v", o_flag_v, oldest_outcome.flag_v);
            end
        end
        instr_taken = i_rst_n && i_in_valid && o_in_ready;
        if (instr_taken)
            predicted_outcomes.push_back(execute_instr(current_instr));
    end

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_out_ready       = 1'b0;
        i_command         = '0;
        i_set_flags       = 1'b0;
        i_operand_form    = '0;
        i_shift_type      = '0;
        i_shift_amount    = '0;
        i_first_operand   = '0;
        i_second_register = '0;
        i_immediate_byte  = '0;
        i_rotate_half     = '0;
        i_carry_in        = 1'b0;
        i_overflow_in     = 1'b0;
        i_dest_is_pc      = 1'b0;
        sender_idle_pct   = 0;
        sink_stall_pct    = 0;
        error_count       = 0;
        cycle_count       = 0;

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: every opcode, operand form and shifter corner
        pending_instrs.push_back(make_instr(adp_pkg::OP_AND, 1'b1, adp_pkg::FORM_ROT_IMM,
            adp_pkg::SH_LSL, 8'd0, 32'hFFFF_FFFF, 32'h0, 8'hFF, 4'd0, 1'b1, 1'b0, 1'b0));
        // non-S EOR with rotated immediate landing on bit 31
        pending_instrs.push_back(make_instr(adp_pkg::OP_EOR, 1'b0, adp_pkg::FORM_ROT_IMM,
            adp_pkg::SH_LSL, 8'd0, 32'h1234_5678, 32'hDEAD_BEEF, 8'h02, 4'd1, 1'b0, 1'b1,
            1'b0));
        // LSL #0 keeps the carry in
        pending_instrs.push_back(make_instr(adp_pkg::OP_SUB, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_LSL, 8'd0, 32'h5, 32'h5, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0));
        // LSR #32
        pending_instrs.push_back(make_instr(adp_pkg::OP_RSB, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_LSR, 8'd0, 32'h0, 32'h8000_0000, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0));
        // ASR #32
        pending_instrs.push_back(make_instr(adp_pkg::OP_ADD, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_ASR, 8'd0, 32'h1, 32'h8000_0001, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0));
        // RRX
        pending_instrs.push_back(make_instr(adp_pkg::OP_ADC, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_ROR, 8'd0, 32'h0, 32'h3, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0));
        // register shift by zero
        pending_instrs.push_back(make_instr(adp_pkg::OP_SBC, 1'b1, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_LSL, 8'd0, 32'h10, 32'h10, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0));
        // LSL by 32 and by 33 from a register
        pending_instrs.push_back(make_instr(adp_pkg::OP_RSC, 1'b1, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_LSL, 8'd32, 32'h7, 32'h1, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0));
        pending_instrs.push_back(make_instr(adp_pkg::OP_RSB, 1'b1, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_LSL, 8'd33, 32'h7, 32'hFFFF_FFFF, 8'h00, 4'd0, 1'b0, 1'b1, 1'b0));
        // tests aimed at the PC still do not route the result
        pending_instrs.push_back(make_instr(adp_pkg::OP_TST, 1'b0, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_LSR, 8'd32, 32'hFFFF_FFFF, 32'h8000_0000, 8'h00, 4'd0, 1'b0, 1'b0,
            1'b1));
        pending_instrs.push_back(make_instr(adp_pkg::OP_TEQ, 1'b0, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_LSR, 8'd33, 32'h0, 32'hFFFF_FFFF, 8'h00, 4'd0, 1'b1, 1'b1, 1'b1));
        // ASR by a large register amount
        pending_instrs.push_back(make_instr(adp_pkg::OP_CMP, 1'b1, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_ASR, 8'd200, 32'hFFFF_FFFF, 32'h8000_0000, 8'h00, 4'd0, 1'b0, 1'b0,
            1'b0));
        // ROR by a multiple of 32, with signed overflow
        pending_instrs.push_back(make_instr(adp_pkg::OP_CMN, 1'b1, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_ROR, 8'd64, 32'h7FFF_FFFF, 32'h1, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0));
        // S with PC destination restores status
        pending_instrs.push_back(make_instr(adp_pkg::OP_ORR, 1'b1, adp_pkg::FORM_SHIFT_REG,
            adp_pkg::SH_ROR, 8'd255, 32'h0, 32'h8000_0001, 8'hFF, 4'd15, 1'b0, 1'b0, 1'b1));
        // spare operand form behaves as register shift
        pending_instrs.push_back(make_instr(adp_pkg::OP_MOV, 1'b1, FORM_SPARE,
            adp_pkg::SH_LSL, 8'd255, 32'h0, 32'hFFFF_FFFF, 8'h00, 4'd0, 1'b1, 1'b1, 1'b0));
        pending_instrs.push_back(make_instr(adp_pkg::OP_ADC, 1'b1, FORM_SPARE,
            adp_pkg::SH_ASR, 8'd0, 32'h1, 32'hFFFF_FFFE, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0));
        // immediate amount uses only the low five bits
        pending_instrs.push_back(make_instr(adp_pkg::OP_BIC, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_ASR, 8'd255, 32'hFFFF_FFFF, 32'h8000_0000, 8'h00, 4'd0, 1'b0, 1'b1,
            1'b0));
        pending_instrs.push_back(make_instr(adp_pkg::OP_ADD, 1'b0, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_LSL, 8'hE0, 32'h1, 32'h1234_5678, 8'h00, 4'd0, 1'b1, 1'b1, 1'b0));
        pending_instrs.push_back(make_instr(adp_pkg::OP_MVN, 1'b0, adp_pkg::FORM_ROT_IMM,
            adp_pkg::SH_ROR, 8'd0, 32'h0, 32'h0, 8'hFF, 4'd15, 1'b1, 1'b1, 1'b1));
        // zero result, unsigned wrap and signed underflow
        pending_instrs.push_back(make_instr(adp_pkg::OP_CMP, 1'b1, adp_pkg::FORM_ROT_IMM,
            adp_pkg::SH_LSL, 8'd0, 32'h0, 32'h0, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0));
        pending_instrs.push_back(make_instr(adp_pkg::OP_ADD, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_LSL, 8'd0, 32'hFFFF_FFFF, 32'h1, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0));
        pending_instrs.push_back(make_instr(adp_pkg::OP_SUB, 1'b1, adp_pkg::FORM_SHIFT_IMM,
            adp_pkg::SH_LSL, 8'd0, 32'h8000_0000, 32'h1, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0));
        wait_for_drain();

        // Random phases; each drains fully before the next starts
        run_phase(120, 0, 0);
        run_phase(120, 71, 0);
        run_phase(120, 0, 71);
        run_phase(120, 21, 21);

        // Allow stray result words to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_outcomes.size() != 0)
            report_error($sformatf("%0d result words never arrived",
                                   predicted_outcomes.size()));
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/adp_pkg.sv
rtl/adp_shifter.sv
rtl/arm_data_processing_alu.sv
bench/testbench.sv
